FILE: rtl/core/cra_pkg.sv
package cra_pkg;

  // Internal CORDIC datapath: 40-bit prescaled values plus growth headroom
  localparam int CW = 42;
  localparam int GUARD = 8;
  localparam int UW = CW - GUARD;
  localparam int DIV_STEPS = 32;

  localparam logic signed [31:0] INVK_Q30 = 32'sd652032874;
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd1367130551;
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cordic_in_t;

  typedef struct packed {
    kind_t              kind;
    logic               a_pol;
    logic               b_pol;
    logic               a_zero;
    logic               b_zero;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic [31:0]        ta;
    logic [31:0]        tb;
  } side_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [UW-1:0] ar;
    logic signed [UW-1:0] ai;
    logic signed [UW-1:0] br;
    logic signed [UW-1:0] bi;
    logic signed [31:0]   am;
    logic signed [31:0]   bm;
    logic [31:0]          rt;
    logic                 sat;
  } merge_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic               sat;
    logic signed [63:0] mprod;
    logic signed [63:0] tprod;
    logic               dz;
    logic               am_neg;
    logic               q_neg;
  } post_t;

  // Arctangent of 2^-i in binary turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/cra_cordic.sv
module cra_cordic import cra_pkg::*; #(
  parameter int STAGES = 24
) (
  input  logic                 clk,
  input  cordic_in_t           cin,
  output logic signed [UW-1:0] x_out,
  output logic signed [UW-1:0] y_out,
  output logic [31:0]          z_out
);

  localparam logic signed [CW-1:0] RND = CW'(1) << (GUARD - 1);

  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  logic [31:0]          zs [0:STAGES];
  logic                 vs [0:STAGES];

  logic signed [CW-1:0] x_init;
  logic signed [CW-1:0] y_init;
  logic [31:0]          z_init;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] yr;

  // Fold into the right half plane before the first micro-rotation
  always_comb begin
    x_init = cin.x;
    y_init = cin.y;
    z_init = cin.z;
    if (cin.vec) begin
      if (cin.x < 0) begin
        x_init = -cin.x;
        y_init = -cin.y;
        z_init = HALF_TURN;
      end
    end else if ((cin.z + QUARTER_TURN) > HALF_TURN) begin
      x_init = -cin.x;
      z_init = cin.z + HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= x_init;
    ys[0] <= y_init;
    zs[0] <= z_init;
    vs[0] <= cin.vec;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                 fwd;
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    logic [31:0]          ang;

    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;
    assign ang = atan_turn(5'(i));
    assign fwd = vs[i] ? ys[i][CW-1] : !zs[i][31];

    always_ff @(posedge clk) begin
      if (fwd) begin
        xs[i+1] <= xs[i] - ysh;
        ys[i+1] <= ys[i] + xsh;
        zs[i+1] <= zs[i] - ang;
      end else begin
        xs[i+1] <= xs[i] + ysh;
        ys[i+1] <= ys[i] - xsh;
        zs[i+1] <= zs[i] + ang;
      end
      vs[i+1] <= vs[i];
    end
  end

  // Drop guard bits, round half up
  assign xr    = xs[STAGES] + RND;
  assign yr    = ys[STAGES] + RND;
  assign x_out = xr[CW-1:GUARD];
  assign y_out = yr[CW-1:GUARD];
  assign z_out = zs[STAGES];

endmodule

FILE: rtl/core/cra_div.sv
module cra_div import cra_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic        ovf
);

  logic [31:0] rem [0:DIV_STEPS];
  logic [31:0] low [0:DIV_STEPS];
  logic [31:0] qs  [0:DIV_STEPS];
  logic [31:0] dn  [0:DIV_STEPS];
  logic        ov  [0:DIV_STEPS];

  logic [31:0] rem_init;

  // Dividend is num scaled by 2^FRAC_BITS; its top FRAC_BITS bits seed the remainder
  assign rem_init = 32'(num[31:32-FRAC_BITS]);

  always_ff @(posedge clk) begin
    rem[0] <= rem_init;
    low[0] <= {num[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    qs[0]  <= '0;
    dn[0]  <= den;
    ov[0]  <= rem_init >= den;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem[k], low[k][31]};
    assign ge    = trial >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? 32'(trial - {1'b0, dn[k]}) : trial[31:0];
      low[k+1] <= {low[k][30:0], 1'b0};
      qs[k+1]  <= {qs[k][30:0], ge};
      dn[k+1]  <= dn[k];
      ov[k+1]  <= ov[k];
    end
  end

  assign quo = qs[DIV_STEPS];
  assign ovf = ov[DIV_STEPS];

endmodule

FILE: rtl/core/complex_arith_rect_polar.sv
// CORDIC complex arithmetic unit. Pulse start with an operation (add, subtract,
// multiply, divide) and two operands, each rectangular or polar, all signed
// Qm.FRAC_BITS; busy is always low, so a new operation may be started in every
// cycle. Each operation returns exactly one result, shown for one cycle while
// done is high. The receiver cannot stall the unit: capture the result in the
// cycle done is high, or lose it. The latency is set by the unrolled CORDIC
// (one register per micro-rotation, plus a fold stage) and the 32-step
// restoring divider (one quotient bit per stage); every operation passes
// through both so results leave in start order. Add and subtract return
// rectangular results; multiply and divide return magnitude and an angle
// wrapped to (-pi, pi]. saturated flags any clamped value; divide_by_zero flags
// a zero divisor magnitude and forces the magnitude to full scale.
module complex_arith_rect_polar import cra_pkg::*; #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic        a_is_polar,
  input  logic signed [31:0] a_first,
  input  logic signed [31:0] a_second,
  input  logic        b_is_polar,
  input  logic signed [31:0] b_first,
  input  logic signed [31:0] b_second,
  output logic        done,
  output logic        result_is_polar,
  output logic signed [31:0] result_first,
  output logic signed [31:0] result_second,
  output logic        divide_by_zero,
  output logic        saturated
);

  localparam int CL = CORDIC_STAGES + 1;
  localparam logic signed [63:0] MUL_RND = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ANG_RND = 64'sd1 <<< (59 - FRAC_BITS);
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic fits32(input logic signed [63:0] v);
    return v[63:31] == {33{v[63]}};
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (fits32(v)) r = v[31:0];
    else if (v[63]) r = S32_MIN;
    else r = S32_MAX;
    return r;
  endfunction

  // No back-pressure anywhere: accept every start
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 0: capture the transfer
  // ---------------------------------------------------------------------------
  logic               s0_valid;
  kind_t              s0_kind;
  logic               s0_a_pol;
  logic               s0_b_pol;
  logic signed [31:0] s0_a1;
  logic signed [31:0] s0_a2;
  logic signed [31:0] s0_b1;
  logic signed [31:0] s0_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_kind  <= kind_t'(kind);
    s0_a_pol <= a_is_polar;
    s0_b_pol <= b_is_polar;
    s0_a1    <= a_first;
    s0_a2    <= a_second;
    s0_b1    <= b_first;
    s0_b2    <= b_second;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: prescale by 1/K and convert radians to binary turns
  // ---------------------------------------------------------------------------
  logic signed [63:0] pa1_w;
  logic signed [63:0] pa2_w;
  logic signed [63:0] pb1_w;
  logic signed [63:0] pb2_w;
  logic signed [63:0] ta_w;
  logic signed [63:0] tb_w;

  assign pa1_w = s0_a1 * INVK_Q30;
  assign pa2_w = s0_a2 * INVK_Q30;
  assign pb1_w = s0_b1 * INVK_Q30;
  assign pb2_w = s0_b2 * INVK_Q30;
  assign ta_w  = s0_a2 * TURN_PER_RAD;
  assign tb_w  = s0_b2 * TURN_PER_RAD;

  logic signed [CW-1:0] s1_pa1;
  logic signed [CW-1:0] s1_pa2;
  logic signed [CW-1:0] s1_pb1;
  logic signed [CW-1:0] s1_pb2;

  side_t          sb [0:CL];
  logic [CL:0]    sb_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= '0;
    end else begin
      sb_valid <= {sb_valid[CL-1:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_pa1       <= CW'(signed'(pa1_w[61:30-GUARD]));
    s1_pa2       <= CW'(signed'(pa2_w[61:30-GUARD]));
    s1_pb1       <= CW'(signed'(pb1_w[61:30-GUARD]));
    s1_pb2       <= CW'(signed'(pb2_w[61:30-GUARD]));
    sb[0].kind   <= s0_kind;
    sb[0].a_pol  <= s0_a_pol;
    sb[0].b_pol  <= s0_b_pol;
    sb[0].a_zero <= (s0_a1 == 32'sd0) && (s0_a2 == 32'sd0);
    sb[0].b_zero <= (s0_b1 == 32'sd0) && (s0_b2 == 32'sd0);
    sb[0].a1     <= s0_a1;
    sb[0].a2     <= s0_a2;
    sb[0].b1     <= s0_b1;
    sb[0].b2     <= s0_b2;
    sb[0].ta     <= ta_w[FRAC_BITS+1 +: 32];
    sb[0].tb     <= tb_w[FRAC_BITS+1 +: 32];
    for (int k = 0; k < CL; k++) begin
      sb[k+1] <= sb[k];
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC: rotate polar operands for add/subtract, vector rectangular
  // operands for multiply/divide
  // ---------------------------------------------------------------------------
  cordic_in_t           cin_a;
  cordic_in_t           cin_b;
  logic signed [UW-1:0] xa;
  logic signed [UW-1:0] ya;
  logic [31:0]          za;
  logic signed [UW-1:0] xb;
  logic signed [UW-1:0] yb;
  logic [31:0]          zb;

  always_comb begin
    cin_a.vec = sb[0].kind[1];
    cin_a.x   = s1_pa1;
    cin_a.y   = sb[0].kind[1] ? s1_pa2 : '0;
    cin_a.z   = sb[0].kind[1] ? '0 : sb[0].ta;
    cin_b.vec = sb[0].kind[1];
    cin_b.x   = s1_pb1;
    cin_b.y   = sb[0].kind[1] ? s1_pb2 : '0;
    cin_b.z   = sb[0].kind[1] ? '0 : sb[0].tb;
  end

  cra_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a (
    .clk   (clk),
    .cin   (cin_a),
    .x_out (xa),
    .y_out (ya),
    .z_out (za)
  );

  cra_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_b (
    .clk   (clk),
    .cin   (cin_b),
    .x_out (xb),
    .y_out (yb),
    .z_out (zb)
  );

  // ---------------------------------------------------------------------------
  // Merge stage: pick CORDIC or pass-through operands, combine angles
  // ---------------------------------------------------------------------------
  side_t  sc;
  merge_t u_next;
  merge_t u_q;
  logic   u_valid;
  logic [31:0] at;
  logic [31:0] bt;
  logic        a_clip;
  logic        b_clip;

  assign sc = sb[CL];

  always_comb begin
    a_clip = !sc.a_pol && !sc.a_zero && !fits32(64'(xa));
    b_clip = !sc.b_pol && !sc.b_zero && !fits32(64'(xb));
    at = sc.a_pol ? sc.ta : (sc.a_zero ? '0 : za);
    bt = sc.b_pol ? sc.tb : (sc.b_zero ? '0 : zb);

    u_next.kind = sc.kind;
    u_next.ar   = sc.a_pol ? xa : UW'(sc.a1);
    u_next.ai   = sc.a_pol ? ya : UW'(sc.a2);
    u_next.br   = sc.b_pol ? xb : UW'(sc.b1);
    u_next.bi   = sc.b_pol ? yb : UW'(sc.b2);
    u_next.am   = sc.a_pol ? sc.a1 : (sc.a_zero ? 32'sd0 : clip32(64'(xa)));
    u_next.bm   = sc.b_pol ? sc.b1 : (sc.b_zero ? 32'sd0 : clip32(64'(xb)));
    u_next.rt   = (sc.kind == KIND_MUL) ? at + bt : at - bt;
    u_next.sat  = sc.kind[1] && (a_clip || b_clip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
    end else begin
      u_valid <= sb_valid[CL];
    end
  end

  always_ff @(posedge clk) begin
    u_q <= u_next;
  end

  // ---------------------------------------------------------------------------
  // Math stage: sums, magnitude product, angle back to radians;
  // divider starts in parallel
  // ---------------------------------------------------------------------------
  logic signed [UW:0]   sum1;
  logic signed [UW:0]   sum2;
  logic signed [32:0]   ang_s;
  post_t                m_next;
  post_t                dly [0:DIV_STEPS];
  logic [DIV_STEPS:0]   d_valid;
  logic [31:0]          num_mag;
  logic [31:0]          den_mag;
  logic [31:0]          quo;
  logic                 quo_ovf;

  always_comb begin
    if (u_q.kind == KIND_SUB) begin
      sum1 = (UW+1)'(u_q.ar) - (UW+1)'(u_q.br);
      sum2 = (UW+1)'(u_q.ai) - (UW+1)'(u_q.bi);
    end else begin
      sum1 = (UW+1)'(u_q.ar) + (UW+1)'(u_q.br);
      sum2 = (UW+1)'(u_q.ai) + (UW+1)'(u_q.bi);
    end
    // Half turn reads as +pi so the angle lands in (-pi, pi]
    ang_s = {u_q.rt[31] & (|u_q.rt[30:0]), u_q.rt};

    m_next.kind   = u_q.kind;
    m_next.r1     = clip32(64'(sum1));
    m_next.r2     = clip32(64'(sum2));
    m_next.sat    = u_q.kind[1] ? u_q.sat : (!fits32(64'(sum1)) || !fits32(64'(sum2)));
    m_next.mprod  = u_q.am * u_q.bm;
    m_next.tprod  = ang_s * PI_Q29;
    m_next.dz     = u_q.bm == 32'sd0;
    m_next.am_neg = u_q.am[31];
    m_next.q_neg  = u_q.am[31] ^ u_q.bm[31];
  end

  assign num_mag = u_q.am[31] ? 32'(-u_q.am) : 32'(u_q.am);
  assign den_mag = u_q.bm[31] ? 32'(-u_q.bm) : 32'(u_q.bm);

  cra_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .num (num_mag),
    .den (den_mag),
    .quo (quo),
    .ovf (quo_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else begin
      d_valid <= {d_valid[DIV_STEPS-1:0], u_valid};
    end
  end

  // Hold the math results alongside the divider
  always_ff @(posedge clk) begin
    dly[0] <= m_next;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dly[k+1] <= dly[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage: round, clamp, select by operation
  // ---------------------------------------------------------------------------
  post_t              pf;
  logic signed [63:0] msum;
  logic signed [63:0] mshift;
  logic signed [63:0] tsum;
  logic signed [63:0] tshift;
  logic               r_polar;
  logic signed [31:0] r1;
  logic signed [31:0] r2;
  logic               r_dz;
  logic               r_sat;

  assign pf = dly[DIV_STEPS];

  always_comb begin
    msum    = pf.mprod + MUL_RND;
    mshift  = msum >>> FRAC_BITS;
    tsum    = pf.tprod + ANG_RND;
    tshift  = tsum >>> (60 - FRAC_BITS);
    r_polar = pf.kind[1];
    r2      = pf.r2;
    r1      = pf.r1;
    r_dz    = 1'b0;
    r_sat   = pf.sat;
    case (pf.kind)
      KIND_ADD, KIND_SUB: begin
        r1 = pf.r1;
      end
      KIND_MUL: begin
        r2    = tshift[31:0];
        r1    = clip32(mshift);
        r_sat = pf.sat || !fits32(mshift);
      end
      KIND_DIV: begin
        r2 = tshift[31:0];
        if (pf.dz) begin
          r_dz  = 1'b1;
          r_sat = 1'b1;
          r1    = pf.am_neg ? S32_MIN : S32_MAX;
        end else if (pf.q_neg) begin
          if (quo_ovf || (quo > 32'h8000_0000)) begin
            r1    = S32_MIN;
            r_sat = 1'b1;
          end else begin
            r1 = -signed'(quo);
          end
        end else begin
          if (quo_ovf || quo[31]) begin
            r1    = S32_MAX;
            r_sat = 1'b1;
          end else begin
            r1 = signed'(quo);
          end
        end
      end
      default: begin
        r1 = pf.r1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    result_is_polar <= r_polar;
    result_first    <= r1;
    result_second   <= r2;
    divide_by_zero  <= r_dz;
    saturated       <= r_sat;
  end

endmodule

FILE: rtl/core/cra_chk.sv
module cra_chk import cra_pkg::*; #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRAC_BITS = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              result_is_polar,
  input logic signed [31:0] result_first,
  input logic signed [31:0] result_second,
  input logic              divide_by_zero,
  input logic              saturated
);

  localparam int LATENCY = CORDIC_STAGES + DIV_STEPS + 6;
  localparam logic signed [31:0] ANG_LIM = 32'sd1 <<< (FRAC_BITS + 2);

  // Every transfer comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result missing after start transfer");

  a_dz_only_polar: assert property (@(posedge clk) disable iff (rst)
    done && !result_is_polar |-> !divide_by_zero)
    else $error("divide_by_zero on rectangular result");

  a_dz_sat: assert property (@(posedge clk) disable iff (rst)
    done && divide_by_zero |-> saturated &&
      (result_first == 32'sh7fff_ffff || result_first == 32'sh8000_0000))
    else $error("zero divisor without full-scale saturated magnitude");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done && result_is_polar |-> (result_second < ANG_LIM) && (result_second > -ANG_LIM))
    else $error("result angle outside wrapped range");

endmodule

bind complex_arith_rect_polar cra_chk #(
  .CORDIC_STAGES (CORDIC_STAGES),
  .FRAC_BITS     (FRAC_BITS)
) u_cra_chk (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .result_is_polar (result_is_polar),
  .result_first    (result_first),
  .result_second   (result_second),
  .divide_by_zero  (divide_by_zero),
  .saturated       (saturated)
);

FILE: tb/complex_arith_rect_polar_tb.sv
`timescale 1ns / 100ps

module complex_arith_rect_polar_tb;
  import cra_pkg::*;

  localparam int STAGES    = 24;
  localparam int FRAC      = 16;
  localparam int LATENCY   = STAGES + 38;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    bit              is_polar;
    logic [31:0]     first;
    logic [31:0]     second;
    bit              dz;
    bit              sat;
  } cplx_result_t;

  logic clk, rst, start;
  kind_t kind;
  logic a_is_polar, b_is_polar;
  logic signed [31:0] a_first, a_second, b_first, b_second;
  logic busy, done, result_is_polar, divide_by_zero, saturated;
  logic signed [31:0] result_first, result_second;

  cplx_result_t pending_results[$];
  int mismatches;
  int cycle_count;
  bit quiet;  // suppress random idling

  logic [31:0] arctan_lut[32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};

  complex_arith_rect_polar dut (
    .clk, .rst, .start, .busy, .kind, .a_is_polar, .a_first, .a_second,
    .b_is_polar, .b_first, .b_second, .done, .result_is_polar,
    .result_first, .result_second, .divide_by_zero, .saturated
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic longint clip32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [31:0] radians_to_turns(longint r);
    logic [63:0] p;
    p = r * 64'sd1367130551;
    return p[48:17];
  endfunction

  function automatic longint turns_to_radians(logic [31:0] t);
    longint s;
    s = longint'(signed'(t));
    if (s == -(64'sd1 << 31)) s = 64'sd1 << 31;
    return (s * 64'sd1686629713 + (64'sd1 << (59 - FRAC))) >>> (60 - FRAC);
  endfunction

  function automatic longint gain_comp(longint v);
    return (v * 64'sd652032874) >>> (30 - GUARD);
  endfunction

  function automatic longint drop_guard(longint v);
    return (v + (64'sd1 << (GUARD - 1))) >>> GUARD;
  endfunction

  task automatic rotate_to_rect(longint m, logic [31:0] t, output longint re,
                                output longint im);
    longint x, y, nx;
    logic [31:0] z, probe;
    x = gain_comp(m);
    y = 0;
    z = t;
    probe = z + QUARTER_TURN;
    // fold angles outside the right half plane by a half turn
    if (probe > HALF_TURN) begin
      x = -x;
      z = z + HALF_TURN;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (!z[31]) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_lut[i];
      end
      x = nx;
    end
    re = drop_guard(x);
    im = drop_guard(y);
  endtask

  task automatic vector_to_polar(longint re, longint im, output longint mag,
                                 output logic [31:0] t, inout bit sat);
    longint x, y, nx;
    logic [31:0] z;
    if (re == 0 && im == 0) begin
      mag = 0;
      t = 0;
      return;
    end
    x = gain_comp(re);
    y = gain_comp(im);
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_lut[i];
      end
      x = nx;
    end
    mag = clip32(drop_guard(x), sat);
    t = z;
  endtask

  task automatic predict_result(kind_t k, bit ap, logic signed [31:0] a1,
                                logic signed [31:0] a2, bit bp,
                                logic signed [31:0] b1, logic signed [31:0] b2,
                                output cplx_result_t res);
    longint ar, ai, br, bi, am, bm, r1, r2;
    logic [31:0] at, bt, rt;
    bit sat, dz;
    sat = 0;
    dz = 0;
    if (k == KIND_ADD || k == KIND_SUB) begin
      ar = a1; ai = a2; br = b1; bi = b2;
      if (ap) rotate_to_rect(a1, radians_to_turns(a2), ar, ai);
      if (bp) rotate_to_rect(b1, radians_to_turns(b2), br, bi);
      if (k == KIND_ADD) begin
        r1 = ar + br;
        r2 = ai + bi;
      end else begin
        r1 = ar - br;
        r2 = ai - bi;
      end
      r1 = clip32(r1, sat);
      r2 = clip32(r2, sat);
    end else begin
      am = a1;
      bm = b1;
      if (ap) at = radians_to_turns(a2);
      else vector_to_polar(a1, a2, am, at, sat);
      if (bp) bt = radians_to_turns(b2);
      else vector_to_polar(b1, b2, bm, bt, sat);
      if (k == KIND_MUL) begin
        r1 = clip32((am * bm + (64'sd1 << (FRAC - 1))) >>> FRAC, sat);
        rt = at + bt;
      end else begin
        if (bm == 0) begin
          // zero divisor: full-scale magnitude with the dividend's sign
          dz = 1;
          sat = 1;
          r1 = (am < 0) ? -64'sd2147483648 : 64'sd2147483647;
        end else begin
          r1 = clip32((am * (64'sd1 << FRAC)) / bm, sat);
        end
        rt = at - bt;
      end
      r2 = turns_to_radians(rt);
    end
    res.is_polar = (k == KIND_MUL || k == KIND_DIV);
    res.first    = r1[31:0];
    res.second   = r2[31:0];
    res.dz       = dz;
    res.sat      = sat;
  endtask

  // ---------------- driver ----------------

  task automatic idle_maybe();
    if (!quiet && $urandom_range(99) < 8) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold start high until the transfer; leave it high for a following item.
  task automatic send_op(kind_t k, bit ap, logic signed [31:0] a1,
                         logic signed [31:0] a2, bit bp, logic signed [31:0] b1,
                         logic signed [31:0] b2);
    cplx_result_t exp_res;
    bit was_busy;
    idle_maybe();
    start      <= 1;
    kind       <= k;
    a_is_polar <= ap;
    a_first    <= a1;
    a_second   <= a2;
    b_is_polar <= bp;
    b_first    <= b1;
    b_second   <= b2;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    predict_result(k, ap, a1, a2, bp, b1, b2, exp_res);
    pending_results.push_back(exp_res);
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    cplx_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        want = pending_results.pop_front();
        if (result_is_polar !== want.is_polar || result_first !== want.first ||
            result_second !== want.second || divide_by_zero !== want.dz ||
            saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pol=%0b f=%h s=%h dz=%0b sat=%0b got pol=%0b f=%h s=%h dz=%0b sat=%0b",
                     want.is_polar, want.first, want.second, want.dz, want.sat,
                     result_is_polar, result_first, result_second,
                     divide_by_zero, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("complex_arith_rect_polar_tb: FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------

  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  task automatic test_extremes();
    send_op(KIND_ADD, 0, MAXV, MAXV, 0, MAXV, MAXV);   // positive overflow
    send_op(KIND_SUB, 0, MINV, MINV, 0, MAXV, MAXV);   // negative overflow
    send_op(KIND_ADD, 0, MINV, MAXV, 0, 0, 0);
    send_op(KIND_MUL, 0, MAXV, MINV, 0, MAXV, MAXV);   // magnitude clamp
    send_op(KIND_MUL, 0, MINV, MINV, 1, MAXV, MINV);
    send_op(KIND_DIV, 1, MAXV, MAXV, 1, 1, MINV);      // quotient overflow
    send_op(KIND_ADD, 1, MAXV, MINV, 1, MINV, MAXV);
    send_op(KIND_SUB, 1, MINV, MAXV, 1, MAXV, MINV);
  endtask

  task automatic test_each_op();
    send_op(KIND_ADD, 0, 3 * ONE, 4 * ONE, 1, 2 * ONE, 32'sd102944);
    send_op(KIND_SUB, 1, 5 * ONE, -32'sd51472, 0, -ONE, ONE);
    send_op(KIND_MUL, 0, 3 * ONE, 4 * ONE, 1, 2 * ONE, 32'sd205887);
    send_op(KIND_DIV, 1, 6 * ONE, 32'sd205887, 0, -ONE, -ONE);
  endtask

  task automatic test_special_cases();
    send_op(KIND_MUL, 0, 0, 0, 0, 0, 0);                 // zero vectors
    send_op(KIND_DIV, 0, ONE, ONE, 0, 0, 0);             // zero divisor, positive
    send_op(KIND_DIV, 0, 0, 0, 1, 0, ONE);               // zero over zero
    send_op(KIND_DIV, 1, -2 * ONE, ONE, 1, 0, 0);        // zero divisor, negative
    send_op(KIND_ADD, 1, -3 * ONE, ONE, 1, -ONE, -ONE);  // negative magnitudes
    send_op(KIND_MUL, 1, -3 * ONE, ONE, 0, -ONE, 0);
    send_op(KIND_MUL, 1, ONE, 32'sd205887, 1, ONE, 32'sd205887); // angle wrap
    send_op(KIND_DIV, 0, -ONE, 0, 0, ONE, 0);            // half-turn angle
    send_op(KIND_ADD, 1, ONE, 20 * ONE, 1, ONE, -30 * ONE);
  endtask

  function automatic logic signed [31:0] rand_val(bit wide);
    if (wide || $urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
  endfunction

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 2);
      send_op(kind_t'($urandom_range(3)), 1'($urandom_range(1)), rand_val(n % 7 == 0),
              rand_val(n % 5 == 0), 1'($urandom_range(1)), rand_val(n % 11 == 0),
              rand_val(n % 13 == 0));
    end
    quiet = 0;
  endtask

  initial begin
    rst = 1;
    start = 0;
    kind = KIND_ADD;
    a_is_polar = 0;
    a_first = 0;
    a_second = 0;
    b_is_polar = 0;
    b_first = 0;
    b_second = 0;
    mismatches = 0;
    cycle_count = 0;
    quiet = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_each_op();
    test_special_cases();
    test_random(1780);
    start <= 0;
    // drain the pipeline
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) $display("complex_arith_rect_polar_tb: PASS");
    else $display("complex_arith_rect_polar_tb: FAIL");
    $finish;
  end

endmodule
